[rtl/b64ud_pkg.sv]
// ----------------------------------------------------------------------------
// b64ud_pkg
// Shared types, constants and the character classifier of the base64 decoder.
// ----------------------------------------------------------------------------
package b64ud_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned TOTAL_W        = 16;
  localparam logic [15:0] MAX_OUT_RESET  = 16'hFFFF;

  localparam logic [6:0] SX_SKIP = 7'd64;
  localparam logic [6:0] SX_PAD  = 7'd65;
  localparam logic [6:0] SX_BAD  = 7'd66;

  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // Everything one input item releases toward the output side.
  typedef struct packed {
    logic [2:0][7:0]      bytes;
    logic [1:0]           nb;
    logic [1:0]           nres;
    logic                 eom;
    status_e              status;
    logic [TOTAL_W-1:0]   total;
  } bundle_t;

  function automatic logic [6:0] classify(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = c - CH_UP_A;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = c - CH_LO_A + 8'd26;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO + 8'd52;
    end else if (c == CH_PLUS || c == CH_AT) begin
      d = 8'd62;
    end else if (c == CH_SLASH || c == CH_STAR) begin
      d = 8'd63;
    end else if (c == CH_LF) begin
      d = {1'b0, SX_SKIP};
    end else if (c == CH_EQ) begin
      d = {1'b0, SX_PAD};
    end else begin
      d = {1'b0, SX_BAD};
    end
    return d[6:0];
  endfunction

endpackage

[rtl/b64ud_core.sv]
// ----------------------------------------------------------------------------
// b64ud_core
// Input register, message state and the single-pass decode of one item.
// ----------------------------------------------------------------------------
module b64ud_core #(
  parameter int unsigned COUNT_BITS = b64ud_pkg::COUNT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          char_code_i,
  input  logic                end_of_message_i,
  input  logic                q_ready_i,
  output logic                push_o,
  output b64ud_pkg::bundle_t  bundle_o
);

  localparam int unsigned SUM_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

  logic                  in_vld_q;
  logic [7:0]            char_q;
  logic                  eom_q;
  logic [15:0]           max_q;
  logic [23:0]           grp_q, grp_d, grp_n, grp_v;
  logic [1:0]            cnt_q, cnt_d, cnt_n;
  logic [COUNT_BITS-1:0] tot_q, tot_d, tot_n;
  logic                  pad_q, pad_d, pad_n;
  b64ud_pkg::status_e    err_q, err_d, err_n;
  logic [6:0]            sx;
  logic [23:0]           gs;
  logic                  full;
  logic [1:0]            need;
  logic [SUM_W-1:0]      sum;
  logic [SUM_W-1:0]      tot_ext;
  logic                  over;
  logic                  advance;

  assign advance    = in_vld_q && q_ready_i;
  assign in_ready_o = !in_vld_q || q_ready_i;

  always_comb begin
    sx    = b64ud_pkg::classify(char_q);
    gs    = {grp_q[17:0], sx[5:0]};
    grp_n = grp_q;
    cnt_n = cnt_q;
    pad_n = pad_q;
    err_n = err_q;
    tot_n = tot_q;
    full  = 1'b0;
    if (!pad_q && err_q == b64ud_pkg::ST_OK) begin
      if (sx == b64ud_pkg::SX_PAD) begin
        pad_n = 1'b1;
      end else if (sx == b64ud_pkg::SX_BAD) begin
        err_n = b64ud_pkg::ST_INVALID;
        grp_n = '0;
        cnt_n = '0;
      end else if (sx < b64ud_pkg::SX_SKIP) begin
        if (cnt_q == 2'd3) begin
          full  = 1'b1;
          grp_n = '0;
          cnt_n = '0;
        end else begin
          grp_n = gs;
          cnt_n = cnt_q + 2'd1;
        end
      end
    end
    grp_v = grp_n;
    need  = 2'd0;
    if (full) begin
      need = 2'd3;
    end else if (eom_q && err_n == b64ud_pkg::ST_OK) begin
      if (cnt_n == 2'd3) begin
        need = 2'd2;
      end else if (cnt_n == 2'd2) begin
        need = 2'd1;
      end
    end
    sum  = SUM_W'(tot_q) + SUM_W'(need);
    over = (need != 2'd0) &&
           ((sum > SUM_W'(max_q)) || ((sum >> COUNT_BITS) != '0));
    bundle_o.bytes = '0;
    bundle_o.nb    = 2'd0;
    if (need != 2'd0) begin
      if (over) begin
        err_n = b64ud_pkg::ST_OVERFLOW;
        grp_n = '0;
        cnt_n = '0;
      end else begin
        tot_n       = sum[COUNT_BITS-1:0];
        bundle_o.nb = need;
        case (need)
          2'd3: begin
            bundle_o.bytes[0] = gs[23:16];
            bundle_o.bytes[1] = gs[15:8];
            bundle_o.bytes[2] = gs[7:0];
          end
          2'd2: begin
            bundle_o.bytes[0] = grp_v[17:10];
            bundle_o.bytes[1] = grp_v[9:2];
          end
          default: begin
            bundle_o.bytes[0] = grp_v[11:4];
          end
        endcase
      end
    end
    tot_ext         = SUM_W'(tot_n);
    bundle_o.eom    = eom_q;
    bundle_o.status = err_n;
    bundle_o.total  = tot_ext[b64ud_pkg::TOTAL_W-1:0];
    bundle_o.nres   = (eom_q && bundle_o.nb == 2'd0) ? 2'd1 : bundle_o.nb;
  end

  assign push_o = advance && (bundle_o.nres != 2'd0);

  always_comb begin
    if (eom_q) begin
      grp_d = '0;
      cnt_d = '0;
      tot_d = '0;
      pad_d = 1'b0;
      err_d = b64ud_pkg::ST_OK;
    end else begin
      grp_d = grp_n;
      cnt_d = cnt_n;
      tot_d = tot_n;
      pad_d = pad_n;
      err_d = err_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      max_q    <= b64ud_pkg::MAX_OUT_RESET;
      grp_q    <= '0;
      cnt_q    <= '0;
      tot_q    <= '0;
      pad_q    <= 1'b0;
      err_q    <= b64ud_pkg::ST_OK;
    end else begin
      if (cfg_valid_i) begin
        max_q <= cfg_data_i;
      end
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        grp_q <= grp_d;
        cnt_q <= cnt_d;
        tot_q <= tot_d;
        pad_q <= pad_d;
        err_q <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_code_i;
      eom_q  <= end_of_message_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (bundle_o.nb != 2'd0) || bundle_o.eom)
    else $error("A bundle without bytes was queued for an item that does not end a message.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && eom_q) |=> (cnt_q == 2'd0) && !pad_q && (tot_q == '0))
    else $error("Message state was not cleared after the end of a message.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != b64ud_pkg::ST_OK) |-> (cnt_q == 2'd0))
    else $error("A sextet group is pending while an error is held.");

endmodule

[rtl/b64ud_outq.sv]
// ----------------------------------------------------------------------------
// b64ud_outq
// Two-entry queue of decoded bundles, one result per cycle while out_ready_i.
// ----------------------------------------------------------------------------
module b64ud_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b64ud_pkg::bundle_t  bundle_i,
  output logic                q_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          data_byte_o,
  output logic                byte_valid_o,
  output logic                last_of_run_o,
  output logic                message_done_o,
  output logic [1:0]          status_o,
  output logic [15:0]         total_bytes_o
);

  b64ud_pkg::bundle_t q_q [2];
  b64ud_pkg::bundle_t head;
  logic               wr_q, rd_q;
  logic [1:0]         cnt_q;
  logic [1:0]         k_q;
  logic               pop;
  logic               take;

  assign q_ready_o   = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign head        = q_q[rd_q];
  assign take        = out_valid_o && out_ready_i;
  assign pop         = take && last_of_run_o;

  always_comb begin
    byte_valid_o   = (k_q < head.nb);
    data_byte_o    = byte_valid_o ? head.bytes[k_q] : 8'd0;
    last_of_run_o  = (k_q == head.nres - 2'd1);
    message_done_o = head.eom && last_of_run_o;
    status_o       = message_done_o ? head.status : b64ud_pkg::ST_OK;
    total_bytes_o  = message_done_o ? head.total : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
      k_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
        k_q  <= 2'd0;
      end else if (take) begin
        k_q <= k_q + 2'd1;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_q[wr_q] <= bundle_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (head.nres != 2'd0) && (k_q < head.nres))
    else $error("The result index ran past the results of the queued item.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !message_done_o |-> (status_o == b64ud_pkg::ST_OK) && (total_bytes_o == 16'd0))
    else $error("Status or total shown on a result that does not end a message.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != 2'd2))
    else $error("A bundle was written into a full queue.");

endmodule

[rtl/base64_url_variant_decoder_unit.sv]
// ----------------------------------------------------------------------------
// base64_url_variant_decoder_unit
// Streaming base64 decoder with a variant alphabet, one character per item.
// ----------------------------------------------------------------------------
// The input channel takes one character and an end-of-message flag per item.
// The output channel gives zero to three result items per input item: decoded
// bytes, and on the last result of a message the status and the byte count.
// The configuration channel writes the output capacity in bytes and is always
// ready; the user must write it only while the block is idle (unchecked).
// An input item is registered, decoded in one pass against the message state
// and its results are queued in a two-entry queue; the first result is
// presented once the item has passed the input register and been written
// into the queue.
// One input item is accepted every cycle while the output side keeps up. An
// item with three results holds the output until all three are taken, so the
// sustained rate is set by the single output port of the result queue.
// When the receiver stalls, the queue fills and then the input register
// holds, and the input channel drops ready until results are taken.
// Reset clears the message state and the queue and sets the capacity to
// 65535 bytes.
// ----------------------------------------------------------------------------
module base64_url_variant_decoder_unit #(
  parameter int unsigned COUNT_BITS = b64ud_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  data_byte_o,
  output logic        byte_valid_o,
  output logic        last_of_run_o,
  output logic        message_done_o,
  output logic [1:0]  status_o,
  output logic [15:0] total_bytes_o
);

  b64ud_pkg::bundle_t bundle;
  logic               push;
  logic               q_ready;

  assign cfg_ready_o = 1'b1;

  b64ud_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .char_code_i,
    .end_of_message_i,
    .q_ready_i (q_ready),
    .push_o    (push),
    .bundle_o  (bundle)
  );

  b64ud_outq u_outq (
    .clk_i,
    .rst_ni,
    .push_i    (push),
    .bundle_i  (bundle),
    .q_ready_o (q_ready),
    .out_valid_o,
    .out_ready_i,
    .data_byte_o,
    .byte_valid_o,
    .last_of_run_o,
    .message_done_o,
    .status_o,
    .total_bytes_o
  );

endmodule
